/* rtl/rotation_matrix_to_quaternion_top_macros.svh */
// Assertion macros used by the checker file.
// Each one samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH

// A condition that must hold at every edge.
`define RMQ_CHECK(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that, once seen, must be followed by another at the next edge.
`define RMQ_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rmq_pkg.sv */
package rmq_pkg;

	localparam int DATA_W = 32;

	// Square root units take a 64-bit radicand and give a 32-bit root.
	localparam int SQRT_IN_W  = 64;
	localparam int SQRT_OUT_W = SQRT_IN_W / 2;

	// Column normalisation divider: 31 quotient bits over a 32-bit length.
	localparam int NORM_Q_W = 31;
	localparam int NORM_D_W = 32;

	// Quaternion divider: 32 quotient bits over a 33-bit divisor s.
	localparam int QUAT_Q_W = 32;
	localparam int QUAT_D_W = 33;

	localparam int NUM_W = 33;
	localparam int RAD_W = 33;

	// Multiply, sum, root, divide, output register.
	localparam int LANE_LAT  = 2 + SQRT_OUT_W + NORM_Q_W + 1;
	// Compare, select, root, divide, output register.
	localparam int MERGE_LAT = 2 + SQRT_OUT_W + QUAT_Q_W + 1;
	localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

	localparam logic [1:0] CASE_TRACE = 2'd0;
	localparam logic [1:0] CASE_X     = 2'd1;
	localparam logic [1:0] CASE_Y     = 2'd2;
	localparam logic [1:0] CASE_Z     = 2'd3;

	typedef logic [2:0][DATA_W-1:0] vec3_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] r0c0;
		logic signed [DATA_W-1:0] r0c1;
		logic signed [DATA_W-1:0] r0c2;
		logic signed [DATA_W-1:0] r1c0;
		logic signed [DATA_W-1:0] r1c1;
		logic signed [DATA_W-1:0] r1c2;
		logic signed [DATA_W-1:0] r2c0;
		logic signed [DATA_W-1:0] r2c1;
		logic signed [DATA_W-1:0] r2c2;
	} mat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] quat_x;
		logic signed [DATA_W-1:0] quat_y;
		logic signed [DATA_W-1:0] quat_z;
		logic signed [DATA_W-1:0] quat_w;
		logic [1:0]               case_taken;
	} quat_t;

endpackage

/* rtl/rmq_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module rmq_isqrt #(
	parameter int IN_W   = rmq_pkg::SQRT_IN_W,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   val,
	input  logic [SIDE_W-1:0] side_in,
	output logic [IN_W/2-1:0] root,
	output logic [SIDE_W-1:0] side_out
);

	localparam int OUT_W = IN_W / 2;
	localparam int RW    = OUT_W + 2;

	logic [RW-1:0]     rem_s  [OUT_W];
	logic [OUT_W-1:0]  root_s [OUT_W];
	logic [IN_W-1:0]   val_s  [OUT_W];
	logic [SIDE_W-1:0] side_s [OUT_W];

	for (genvar g = 0; g < OUT_W; g++) begin : g_stage
		logic [RW-1:0]     p_rem;
		logic [OUT_W-1:0]  p_root;
		logic [IN_W-1:0]   p_val;
		logic [SIDE_W-1:0] p_side;
		logic [RW-1:0]     rem2;
		logic [RW-1:0]     trial;
		logic              ge;

		if (g == 0) begin : g_first
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_val  = val;
			assign p_side = side_in;
		end else begin : g_next
			assign p_rem  = rem_s[g-1];
			assign p_root = root_s[g-1];
			assign p_val  = val_s[g-1];
			assign p_side = side_s[g-1];
		end

		// Bring down the next two radicand bits and try the next root bit.
		assign rem2  = {p_rem[RW-3:0], p_val[IN_W-1-2*g -: 2]};
		assign trial = {p_root, 2'b01};
		assign ge    = (rem2 >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= ge ? (rem2 - trial) : rem2;
				root_s[g] <= {p_root[OUT_W-2:0], ge};
				val_s[g]  <= p_val;
				side_s[g] <= p_side;
			end
		end
	end

	assign root     = root_s[OUT_W-1];
	assign side_out = side_s[OUT_W-1];

endmodule

/* rtl/rmq_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// The starting partial remainder must be below the divisor.
module rmq_div #(
	parameter int Q_W    = rmq_pkg::NORM_Q_W,
	parameter int D_W    = rmq_pkg::NORM_D_W,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [D_W-1:0]    rem_in,
	input  logic [Q_W-1:0]    lo,
	input  logic [D_W-1:0]    divisor,
	input  logic [SIDE_W-1:0] side_in,
	output logic [Q_W-1:0]    quo,
	output logic [SIDE_W-1:0] side_out
);

	logic [D_W-1:0]    rem_s  [Q_W];
	logic [Q_W-1:0]    lo_s   [Q_W];
	logic [D_W-1:0]    div_s  [Q_W];
	logic [Q_W-1:0]    quo_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];

	for (genvar g = 0; g < Q_W; g++) begin : g_stage
		logic [D_W-1:0]    p_rem;
		logic [Q_W-1:0]    p_lo;
		logic [D_W-1:0]    p_div;
		logic [Q_W-1:0]    p_quo;
		logic [SIDE_W-1:0] p_side;
		logic [D_W:0]      r2;
		logic [D_W:0]      dext;
		logic [D_W:0]      diff;
		logic              ge;

		if (g == 0) begin : g_first
			assign p_rem  = rem_in;
			assign p_lo   = lo;
			assign p_div  = divisor;
			assign p_quo  = '0;
			assign p_side = side_in;
		end else begin : g_next
			assign p_rem  = rem_s[g-1];
			assign p_lo   = lo_s[g-1];
			assign p_div  = div_s[g-1];
			assign p_quo  = quo_s[g-1];
			assign p_side = side_s[g-1];
		end

		// Shift in the next dividend bit and subtract where it fits.
		assign r2   = {p_rem, p_lo[Q_W-1-g]};
		assign dext = {1'b0, p_div};
		assign diff = r2 - dext;
		assign ge   = (r2 >= dext);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= ge ? diff[D_W-1:0] : r2[D_W-1:0];
				lo_s[g]   <= p_lo;
				div_s[g]  <= p_div;
				quo_s[g]  <= {p_quo[Q_W-2:0], ge};
				side_s[g] <= p_side;
			end
		end
	end

	assign quo      = quo_s[Q_W-1];
	assign side_out = side_s[Q_W-1];

endmodule

/* rtl/rmq_lane.sv */
// One column lane: scales a column of the matrix to unit length.
module rmq_lane (
	input  logic          clk,
	input  logic          en,
	input  rmq_pkg::vec3_t col,
	output rmq_pkg::vec3_t norm
);

	localparam int W     = rmq_pkg::DATA_W;
	localparam int SIDEQ = 1 + 3 * W;
	localparam int SIDED = 2 + 26;

	logic [2*W-1:0]        sq_s1 [3];
	rmq_pkg::vec3_t        a_s1;
	logic [2*W-1:0]        sum_s2;
	rmq_pkg::vec3_t        a_s2;
	logic                  keep;
	logic [W-1:0]          len;
	logic [SIDEQ-1:0]      side_sq;
	logic                  keep_r;
	rmq_pkg::vec3_t        a_r;
	logic [rmq_pkg::NORM_Q_W-1:0] quo [3];
	logic [SIDED-1:0]      side_dv [3];
	rmq_pkg::vec3_t        norm_s3;

	// Squares of the three entries.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= 64'($signed(col[i]) * $signed(col[i]));
			end
			a_s1 <= col;
		end
	end

	// Squared length, Q16.48.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			a_s2   <= a_s1;
		end
	end

	// A column of length exactly one, or zero, is passed through unscaled.
	assign keep = (sum_s2 == '0) || (sum_s2 == 64'h0001_0000_0000_0000);

	rmq_isqrt #(
		.IN_W   (rmq_pkg::SQRT_IN_W),
		.SIDE_W (SIDEQ)
	) u_len (
		.clk      (clk),
		.en       (en),
		.val      (sum_s2),
		.side_in  ({keep, a_s2}),
		.root     (len),
		.side_out (side_sq)
	);

	assign keep_r = side_sq[SIDEQ-1];
	assign a_r    = side_sq[SIDEQ-2:0];

	// Each entry: trunc(a * 2^30 / len) on the magnitude.
	for (genvar i = 0; i < 3; i++) begin : g_row
		logic          neg;
		logic [W-1:0]  mag;

		assign neg = a_r[i][W-1];
		assign mag = neg ? (W'(0) - a_r[i]) : a_r[i];

		rmq_div #(
			.Q_W    (rmq_pkg::NORM_Q_W),
			.D_W    (rmq_pkg::NORM_D_W),
			.SIDE_W (SIDED)
		) u_div (
			.clk      (clk),
			.en       (en),
			.rem_in   ({1'b0, mag[W-1:1]}),
			.lo       ({mag[0], 30'b0}),
			.divisor  (len),
			.side_in  ({neg, keep_r, a_r[i][25:0]}),
			.quo      (quo[i]),
			.side_out (side_dv[i])
		);
	end

	// Put the sign back, or take the entry times 64 for a kept column.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (side_dv[i][SIDED-2]) begin
					norm_s3[i] <= {side_dv[i][25:0], 6'b0};
				end else if (side_dv[i][SIDED-1]) begin
					norm_s3[i] <= W'(0) - {1'b0, quo[i]};
				end else begin
					norm_s3[i] <= {1'b0, quo[i]};
				end
			end
		end
	end

	assign norm = norm_s3;

endmodule

/* rtl/rotation_matrix_to_quaternion_top.sv */
// Channel   Direction  Payload          Handshake
// mat       in         rmq_pkg::mat_t   mat_valid, mat_stall
// quat      out        rmq_pkg::quat_t  quat_valid, quat_stall
//
// One matrix is taken every cycle while mat_stall is low.
// The pipeline runs through two pipelined square roots (32 stages each) and two pipelined
// dividers (31 and 32 stages), one result bit per stage.
// Reset clears only the valid bits; data registers carry no reset.
// The whole pipeline holds while a result waits under quat_stall, and mat_stall follows.
module rotation_matrix_to_quaternion_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mat_valid,
	output logic           mat_stall,
	input  rmq_pkg::mat_t  mat,
	output logic           quat_valid,
	input  logic           quat_stall,
	output rmq_pkg::quat_t quat
);

	localparam int W     = rmq_pkg::DATA_W;
	localparam int NW    = rmq_pkg::NUM_W;
	localparam int LAT   = rmq_pkg::TOTAL_LAT;
	localparam int SIDEQ = 2 + 3 * NW;
	localparam int SIDED = 3 + 2 + 31;

	logic                  en;
	logic [LAT-1:0]        vld_q;
	rmq_pkg::vec3_t        col [3];
	rmq_pkg::vec3_t        norm [3];
	logic signed [W-1:0]   n00, n01, n02, n10, n11, n12, n20, n21, n22;

	logic                  tr_pos_s1, x_big_s1, y_big_s1;
	logic signed [34:0]    rt_s1, rx_s1, ry_s1, rz_s1;
	logic signed [NW-1:0]  d21_s1, d02_s1, d10_s1, s01_s1, s02_s1, s12_s1;

	logic [1:0]            sel_s2;
	logic [rmq_pkg::RAD_W-1:0] rad_s2;
	logic signed [NW-1:0]  num_s2 [3];

	logic [W-1:0]          root;
	logic [SIDEQ-1:0]      side_sq;
	logic [1:0]            sel_r;
	logic [NW-1:0]         num_r [3];
	logic [W:0]            s_div;
	logic [30:0]           half;

	logic [rmq_pkg::QUAT_Q_W-1:0] quo [3];
	logic [SIDED-1:0]      side_dv [3];
	logic [W-1:0]          comp [3];
	logic [W-1:0]          half_w;
	rmq_pkg::quat_t        quat_q;

	function automatic logic signed [34:0] sx35(input logic [W-1:0] v);
		sx35 = {{3{v[W-1]}}, v};
	endfunction

	function automatic logic signed [NW-1:0] sx33(input logic [W-1:0] v);
		sx33 = {v[W-1], v};
	endfunction

	// The whole pipeline moves unless a finished result is being held.
	assign en        = !quat_valid || !quat_stall;
	assign mat_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], mat_valid};
		end
	end

	assign quat_valid = vld_q[LAT-1];

	// Column lanes, index is the row.
	assign col[0] = {mat.r2c0, mat.r1c0, mat.r0c0};
	assign col[1] = {mat.r2c1, mat.r1c1, mat.r0c1};
	assign col[2] = {mat.r2c2, mat.r1c2, mat.r0c2};

	for (genvar j = 0; j < 3; j++) begin : g_lane
		rmq_lane u_lane (
			.clk  (clk),
			.en   (en),
			.col  (col[j]),
			.norm (norm[j])
		);
	end

	assign n00 = norm[0][0];
	assign n10 = norm[0][1];
	assign n20 = norm[0][2];
	assign n01 = norm[1][0];
	assign n11 = norm[1][1];
	assign n21 = norm[1][2];
	assign n02 = norm[2][0];
	assign n12 = norm[2][1];
	assign n22 = norm[2][2];

	// Merge: trace test, diagonal compares, all radicands and numerators.
	always_ff @(posedge clk) begin
		if (en) begin
			tr_pos_s1 <= (sx35(n00) + sx35(n11) + sx35(n22)) > 35'sd0;
			x_big_s1  <= (n00 > n11) && (n00 > n22);
			y_big_s1  <= (n11 > n22);
			rt_s1     <= 35'sd1073741824 + sx35(n00) + sx35(n11) + sx35(n22);
			rx_s1     <= 35'sd1073741824 + sx35(n00) - sx35(n11) - sx35(n22);
			ry_s1     <= 35'sd1073741824 + sx35(n11) - sx35(n00) - sx35(n22);
			rz_s1     <= 35'sd1073741824 + sx35(n22) - sx35(n00) - sx35(n11);
			d21_s1    <= sx33(n21) - sx33(n12);
			d02_s1    <= sx33(n02) - sx33(n20);
			d10_s1    <= sx33(n10) - sx33(n01);
			s01_s1    <= sx33(n01) + sx33(n10);
			s02_s1    <= sx33(n02) + sx33(n20);
			s12_s1    <= sx33(n12) + sx33(n21);
		end
	end

	// Pick the case, clamp the radicand and route the three numerators.
	always_ff @(posedge clk) begin
		logic signed [34:0] rad;
		if (en) begin
			if (tr_pos_s1) begin
				sel_s2    <= rmq_pkg::CASE_TRACE;
				rad        = rt_s1;
				num_s2[0] <= d21_s1;
				num_s2[1] <= d02_s1;
				num_s2[2] <= d10_s1;
			end else if (x_big_s1) begin
				sel_s2    <= rmq_pkg::CASE_X;
				rad        = rx_s1;
				num_s2[0] <= s01_s1;
				num_s2[1] <= s02_s1;
				num_s2[2] <= d21_s1;
			end else if (y_big_s1) begin
				sel_s2    <= rmq_pkg::CASE_Y;
				rad        = ry_s1;
				num_s2[0] <= s01_s1;
				num_s2[1] <= s12_s1;
				num_s2[2] <= d02_s1;
			end else begin
				sel_s2    <= rmq_pkg::CASE_Z;
				rad        = rz_s1;
				num_s2[0] <= s02_s1;
				num_s2[1] <= s12_s1;
				num_s2[2] <= d10_s1;
			end
			rad_s2 <= rad[34] ? '0 : rad[rmq_pkg::RAD_W-1:0];
		end
	end

	// q = floor(sqrt(rad * 2^30)).
	rmq_isqrt #(
		.IN_W   (rmq_pkg::SQRT_IN_W),
		.SIDE_W (SIDEQ)
	) u_root (
		.clk      (clk),
		.en       (en),
		.val      ({1'b0, rad_s2, 30'b0}),
		.side_in  ({sel_s2, num_s2[0], num_s2[1], num_s2[2]}),
		.root     (root),
		.side_out (side_sq)
	);

	assign sel_r    = side_sq[SIDEQ-1 -: 2];
	assign num_r[0] = side_sq[3*NW-1 -: NW];
	assign num_r[1] = side_sq[2*NW-1 -: NW];
	assign num_r[2] = side_sq[NW-1 -: NW];
	assign s_div    = {root, 1'b0};
	assign half     = root[W-1:1];

	// Off-diagonal components: trunc(num * 2^30 / s), with overflow caught up front.
	for (genvar k = 0; k < 3; k++) begin : g_quo
		logic          neg;
		logic [NW-1:0] mag;
		logic          ovf;
		logic          szero;

		assign neg   = num_r[k][NW-1];
		assign mag   = neg ? (NW'(0) - num_r[k]) : num_r[k];
		assign szero = (s_div == '0);
		assign ovf   = ({2'b0, mag[NW-1:2]} >= s_div);

		rmq_div #(
			.Q_W    (rmq_pkg::QUAT_Q_W),
			.D_W    (rmq_pkg::QUAT_D_W),
			.SIDE_W (SIDED)
		) u_div (
			.clk      (clk),
			.en       (en),
			.rem_in   ({2'b0, mag[NW-1:2]}),
			.lo       ({mag[1:0], 30'b0}),
			.divisor  (s_div),
			.side_in  ({neg, ovf, szero, sel_r, half}),
			.quo      (quo[k]),
			.side_out (side_dv[k])
		);

		// Zero divisor, then saturation, then the signed quotient.
		always_comb begin
			if (side_dv[k][SIDED-3]) begin
				comp[k] = '0;
			end else if (side_dv[k][SIDED-1]) begin
				if (side_dv[k][SIDED-2] || (quo[k] > 32'h8000_0000)) begin
					comp[k] = 32'h8000_0000;
				end else begin
					comp[k] = W'(0) - quo[k];
				end
			end else begin
				if (side_dv[k][SIDED-2] || quo[k][W-1]) begin
					comp[k] = 32'h7FFF_FFFF;
				end else begin
					comp[k] = quo[k];
				end
			end
		end
	end

	assign half_w = {1'b0, side_dv[0][30:0]};

	// Output register: place the diagonal component by case.
	always_ff @(posedge clk) begin
		if (en) begin
			quat_q.case_taken <= side_dv[0][32:31];
			case (side_dv[0][32:31])
				rmq_pkg::CASE_TRACE: begin
					quat_q.quat_x <= comp[0];
					quat_q.quat_y <= comp[1];
					quat_q.quat_z <= comp[2];
					quat_q.quat_w <= half_w;
				end
				rmq_pkg::CASE_X: begin
					quat_q.quat_x <= half_w;
					quat_q.quat_y <= comp[0];
					quat_q.quat_z <= comp[1];
					quat_q.quat_w <= comp[2];
				end
				rmq_pkg::CASE_Y: begin
					quat_q.quat_x <= comp[0];
					quat_q.quat_y <= half_w;
					quat_q.quat_z <= comp[1];
					quat_q.quat_w <= comp[2];
				end
				default: begin
					quat_q.quat_x <= comp[0];
					quat_q.quat_y <= comp[1];
					quat_q.quat_z <= half_w;
					quat_q.quat_w <= comp[2];
				end
			endcase
		end
	end

	assign quat = quat_q;

endmodule

/* rtl/rmq_checker.sv */
`include "rotation_matrix_to_quaternion_top_macros.svh"

// Port-level checks on the top level.
module rmq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           mat_valid,
	input logic           mat_stall,
	input rmq_pkg::mat_t  mat,
	input logic           quat_valid,
	input logic           quat_stall,
	input rmq_pkg::quat_t quat
);

	logic held_out;
	logic held_in;
	logic diag_ok;

	assign held_out = quat_valid && quat_stall;
	assign held_in  = mat_valid && mat_stall;

	// The diagonal component of the case taken must have a clear sign bit.
	always_comb begin
		case (quat.case_taken)
			rmq_pkg::CASE_TRACE: diag_ok = !quat.quat_w[31];
			rmq_pkg::CASE_X:     diag_ok = !quat.quat_x[31];
			rmq_pkg::CASE_Y:     diag_ok = !quat.quat_y[31];
			default:             diag_ok = !quat.quat_z[31];
		endcase
	end

	// A held result keeps its value until its transfer.
	`RMQ_CHECK_NEXT(a_out_hold, held_out, quat_valid && $stable(quat), "held result changed")

	// A stalled matrix keeps its value until its transfer.
	`RMQ_CHECK_NEXT(a_in_hold, held_in, mat_valid && $stable(mat), "held matrix changed")

	// The input is only held back by a result waiting at the output.
	`RMQ_CHECK(a_in_stall, !mat_stall || held_out, "input stalled without cause")

	// The diagonal component, s/4, is never negative.
	`RMQ_CHECK(a_diag_sign, !quat_valid || diag_ok, "negative diagonal component")

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (.*);
